// ----- src/stgd_pkg.sv -----
// Types and constants shared by the shake / tap gesture detector.
package stgd_pkg;

    // Sample and timestamp widths
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_W      = 48;
    localparam int END_W       = TIME_W + 1;

    // Configuration register widths
    localparam int THR_W  = 18;
    localparam int WIN_W  = 24;
    localparam int HITS_W = 8;
    localparam int COOL_W = 24;

    // Summed axis change: three absolute differences of SAMPLE_BITS each
    localparam int SUM_W   = SAMPLE_BITS + 2;
    localparam int DELTA_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH_US   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_MIN_HITS     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_LENGTH_US = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [THR_W-1:0]  RST_DELTA_THRESHOLD    = THR_W'(6500);
    localparam logic [WIN_W-1:0]  RST_WINDOW_LENGTH_US   = WIN_W'(420000);
    localparam logic [HITS_W-1:0] RST_SHAKE_MIN_HITS     = HITS_W'(5);
    localparam logic [COOL_W-1:0] RST_COOLDOWN_LENGTH_US = COOL_W'(700000);

    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    // Input transaction: one timestamped sample
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [TIME_W-1:0]             sample_time_us;
    } t_sample;

    // Output transaction: one detected gesture
    typedef struct packed {
        logic              gesture_is_shake;
        logic [HITS_W-1:0] window_hits;
    } t_gesture;

endpackage

// ----- src/shake_tap_gesture_detector.sv -----
// Shake / tap gesture detector: top level with sample, window and cooldown logic.
//
//  channel  direction  signals                                   moves
//  in       sink       i_in_valid  o_in_ready  i_in_data         one t_sample
//  out      source     o_out_valid i_out_ready o_out_data        one t_gesture
//  cfg      sink       i_cfg_valid o_cfg_ready i_cfg_index/data  one register write
//
// A sample is taken into the input register, then evaluated combinationally against the
// stored sample, window and cooldown state; a gesture lands in the output register.
// Throughput is one sample per cycle while a held result is not stalled by i_out_ready.
// While a result is held, a waiting sample stalls and o_in_ready follows i_out_ready.
// Synchronous active-low reset clears control state and restores register defaults.
// Configuration writes are always accepted; the user must change registers only while idle (not enforced).
module shake_tap_gesture_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  stgd_pkg::t_sample                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output stgd_pkg::t_gesture                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stgd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stgd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int S = stgd_pkg::SAMPLE_BITS;

    // Configuration registers
    logic [stgd_pkg::THR_W-1:0]  r_delta_threshold;
    logic [stgd_pkg::WIN_W-1:0]  r_window_length_us;
    logic [stgd_pkg::HITS_W-1:0] r_shake_min_hits;
    logic [stgd_pkg::COOL_W-1:0] r_cooldown_length_us;

    // Pipeline registers
    logic               r_in_valid;
    stgd_pkg::t_sample  r_in;
    logic               r_out_valid;
    stgd_pkg::t_gesture r_out;

    // Detector state
    logic signed [S-1:0]          r_prev_x, r_prev_y, r_prev_z;
    logic                         r_have_prev;
    logic                         r_window_open;
    logic [stgd_pkg::HITS_W-1:0]  r_hit_count;
    logic [stgd_pkg::TIME_W-1:0]  r_window_start;
    logic [stgd_pkg::END_W-1:0]   r_cooldown_end;

    // Next-state values
    logic                         n_window_open;
    logic [stgd_pkg::HITS_W-1:0]  n_hit_count;
    logic [stgd_pkg::TIME_W-1:0]  n_window_start;
    logic [stgd_pkg::END_W-1:0]   n_cooldown_end;

    logic                         w_adv;
    logic                         w_emit;
    logic                         w_in_cool;
    logic                         w_hit;
    logic [S:0]                   w_dx, w_dy, w_dz;
    logic [S-1:0]                 w_ax, w_ay, w_az;
    logic [stgd_pkg::DELTA_W-1:0] w_delta;
    logic [stgd_pkg::TIME_W-1:0]  w_now;
    logic [stgd_pkg::TIME_W-1:0]  w_elapsed;

    // Advance the input register whenever the output register can take a result
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Motion delta: sum of absolute axis differences from the stored sample
    always_comb begin
        w_dx = {r_in.accel_x[S-1], r_in.accel_x} - {r_prev_x[S-1], r_prev_x};
        w_dy = {r_in.accel_y[S-1], r_in.accel_y} - {r_prev_y[S-1], r_prev_y};
        w_dz = {r_in.accel_z[S-1], r_in.accel_z} - {r_prev_z[S-1], r_prev_z};
        w_ax = w_dx[S] ? S'(-w_dx) : w_dx[S-1:0];
        w_ay = w_dy[S] ? S'(-w_dy) : w_dy[S-1:0];
        w_az = w_dz[S] ? S'(-w_dz) : w_dz[S-1:0];
        w_delta = stgd_pkg::DELTA_W'(w_ax) + stgd_pkg::DELTA_W'(w_ay)
                + stgd_pkg::DELTA_W'(w_az);
    end

    // Window, hit count and cooldown update for the sample in the input register
    always_comb begin
        w_now          = r_in.sample_time_us;
        w_in_cool      = {1'b0, w_now} < r_cooldown_end;
        w_hit          = w_delta >= stgd_pkg::DELTA_W'(r_delta_threshold);
        n_window_open  = r_window_open;
        n_hit_count    = r_hit_count;
        n_window_start = r_window_start;
        n_cooldown_end = r_cooldown_end;
        w_emit         = 1'b0;
        w_elapsed      = '0;
        if (r_have_prev && !w_in_cool) begin
            if (w_hit) begin
                if (!r_window_open) begin
                    n_window_open  = 1'b1;
                    n_window_start = w_now;
                    n_hit_count    = '0;
                end
                if (n_hit_count != stgd_pkg::HITS_MAX) begin
                    n_hit_count = n_hit_count + 1'b1;
                end
            end
            w_elapsed = w_now - n_window_start;
            if (n_window_open && (w_now >= n_window_start) &&
                (w_elapsed >= stgd_pkg::TIME_W'(r_window_length_us))) begin
                w_emit         = 1'b1;
                n_window_open  = 1'b0;
                n_cooldown_end = {1'b0, w_now} + stgd_pkg::END_W'(r_cooldown_length_us);
            end
        end
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_threshold    <= stgd_pkg::RST_DELTA_THRESHOLD;
            r_window_length_us   <= stgd_pkg::RST_WINDOW_LENGTH_US;
            r_shake_min_hits     <= stgd_pkg::RST_SHAKE_MIN_HITS;
            r_cooldown_length_us <= stgd_pkg::RST_COOLDOWN_LENGTH_US;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stgd_pkg::CFG_DELTA_THRESHOLD: begin
                    r_delta_threshold <= i_cfg_data[stgd_pkg::THR_W-1:0];
                end
                stgd_pkg::CFG_WINDOW_LENGTH_US: begin
                    r_window_length_us <= i_cfg_data[stgd_pkg::WIN_W-1:0];
                end
                stgd_pkg::CFG_SHAKE_MIN_HITS: begin
                    r_shake_min_hits <= i_cfg_data[stgd_pkg::HITS_W-1:0];
                end
                stgd_pkg::CFG_COOLDOWN_LENGTH_US: begin
                    r_cooldown_length_us <= i_cfg_data[stgd_pkg::COOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a transaction when it is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Output register: load a gesture or drop a taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out.gesture_is_shake <= n_hit_count >= r_shake_min_hits;
            r_out.window_hits      <= n_hit_count;
        end
    end

    // Detector state: store the sample and advance window and cooldown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_prev_z       <= '0;
            r_have_prev    <= 1'b0;
            r_window_open  <= 1'b0;
            r_hit_count    <= '0;
            r_window_start <= '0;
            r_cooldown_end <= '0;
        end else if (w_adv) begin
            r_prev_x       <= r_in.accel_x;
            r_prev_y       <= r_in.accel_y;
            r_prev_z       <= r_in.accel_z;
            r_have_prev    <= 1'b1;
            r_window_open  <= n_window_open;
            r_hit_count    <= n_hit_count;
            r_window_start <= n_window_start;
            r_cooldown_end <= n_cooldown_end;
        end
    end

    // A window only ever opens on a hit, so every gesture carries at least one
    a_hits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.window_hits != '0))
        else $error("gesture reported with zero hits");

    a_open_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_open |-> (r_hit_count != '0))
        else $error("open window without a hit");

    a_no_window_before_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_prev |-> !r_window_open)
        else $error("window open before the first sample");

    a_close_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (!r_window_open && o_out_valid))
        else $error("gesture did not close the window");

    a_cooldown_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (r_cooldown_end >= {1'b0, $past(r_in.sample_time_us)}))
        else $error("cooldown end below gesture time");

endmodule

// ----- test/tb_shake_tap_gesture_detector.sv -----
// Self-checking testbench for the shake / tap gesture detector.
`timescale 1ns / 100ps

module tb_shake_tap_gesture_detector;

    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [stgd_pkg::TIME_W-1:0] TIME_MAX = {stgd_pkg::TIME_W{1'b1}};
    localparam logic [stgd_pkg::TIME_W-1:0] TIME_TOP = TIME_MAX - stgd_pkg::TIME_W'(4095);

    // Tracks the detector state and queues the gestures it must report
    class gesture_tracker;
        logic [stgd_pkg::THR_W-1:0]              thr;
        logic [stgd_pkg::WIN_W-1:0]              win_len;
        logic [stgd_pkg::HITS_W-1:0]             min_hits;
        logic [stgd_pkg::COOL_W-1:0]             cool_len;
        logic signed [stgd_pkg::SAMPLE_BITS-1:0] last_x, last_y, last_z;
        bit                                      have_last;
        bit                                      win_open;
        logic [stgd_pkg::HITS_W-1:0]             hits;
        logic [stgd_pkg::TIME_W-1:0]             win_start;
        logic [stgd_pkg::END_W-1:0]              cool_end;
        stgd_pkg::t_gesture                      pending_gestures[$];
        int n_samples, n_gestures, n_shakes, n_saturated, n_writes, n_errors;

        function new();
            thr       = stgd_pkg::RST_DELTA_THRESHOLD;
            win_len   = stgd_pkg::RST_WINDOW_LENGTH_US;
            min_hits  = stgd_pkg::RST_SHAKE_MIN_HITS;
            cool_len  = stgd_pkg::RST_COOLDOWN_LENGTH_US;
            last_x    = '0;
            last_y    = '0;
            last_z    = '0;
            have_last = 0;
            win_open  = 0;
            hits      = '0;
            win_start = '0;
            cool_end  = '0;
        endfunction

        // Apply one register write; unknown indexes are dropped
        function void write_reg(logic [stgd_pkg::CFG_IDX_W-1:0] idx,
                                logic [stgd_pkg::CFG_DATA_W-1:0] data);
            n_writes++;
            case (idx)
                stgd_pkg::CFG_DELTA_THRESHOLD:    thr      = data[stgd_pkg::THR_W-1:0];
                stgd_pkg::CFG_WINDOW_LENGTH_US:   win_len  = data[stgd_pkg::WIN_W-1:0];
                stgd_pkg::CFG_SHAKE_MIN_HITS:     min_hits = data[stgd_pkg::HITS_W-1:0];
                stgd_pkg::CFG_COOLDOWN_LENGTH_US: cool_len = data[stgd_pkg::COOL_W-1:0];
                default: ;
            endcase
        endfunction

        function int abs_gap(logic signed [stgd_pkg::SAMPLE_BITS-1:0] a,
                             logic signed [stgd_pkg::SAMPLE_BITS-1:0] b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        // Advance the detector by one accepted sample transaction
        function void take_sample(stgd_pkg::t_sample s);
            int                 motion;
            stgd_pkg::t_gesture g;
            n_samples++;
            if (!have_last) begin
                last_x    = s.accel_x;
                last_y    = s.accel_y;
                last_z    = s.accel_z;
                have_last = 1;
                return;
            end
            motion = abs_gap(s.accel_x, last_x) + abs_gap(s.accel_y, last_y)
                   + abs_gap(s.accel_z, last_z);
            last_x = s.accel_x;
            last_y = s.accel_y;
            last_z = s.accel_z;

            // drop samples inside the cooldown
            if ({1'b0, s.sample_time_us} < cool_end)
                return;

            if (motion >= int'(thr)) begin
                if (!win_open) begin
                    win_open  = 1;
                    win_start = s.sample_time_us;
                    hits      = '0;
                end
                if (hits != stgd_pkg::HITS_MAX)
                    hits++;
            end

            // close the window once it has run its length
            if (win_open && s.sample_time_us >= win_start &&
                s.sample_time_us - win_start >= stgd_pkg::TIME_W'(win_len)) begin
                g.gesture_is_shake = (hits >= min_hits);
                g.window_hits      = hits;
                pending_gestures.push_back(g);
                win_open = 0;
                cool_end = {1'b0, s.sample_time_us} + stgd_pkg::END_W'(cool_len);
            end
        endfunction

        // Compare one reported gesture with the oldest one queued
        function void match_gesture(stgd_pkg::t_gesture got);
            stgd_pkg::t_gesture want;
            if (pending_gestures.size() == 0) begin
                $error("gesture with none pending: gesture_is_shake %0d window_hits %0d",
                       got.gesture_is_shake, got.window_hits);
                n_errors++;
                return;
            end
            want = pending_gestures.pop_front();
            n_gestures++;
            if (want.gesture_is_shake)
                n_shakes++;
            if (want.window_hits == stgd_pkg::HITS_MAX)
                n_saturated++;
            if (got.gesture_is_shake !== want.gesture_is_shake) begin
                $error("gesture_is_shake: expected %0d, actual %0d",
                       want.gesture_is_shake, got.gesture_is_shake);
                n_errors++;
            end
            if (got.window_hits !== want.window_hits) begin
                $error("window_hits: expected %0d, actual %0d",
                       want.window_hits, got.window_hits);
                n_errors++;
            end
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    stgd_pkg::t_sample               in_data   = '0;
    logic                            out_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [stgd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [stgd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    stgd_pkg::t_gesture              o_out_data;
    logic                            o_cfg_ready;

    bit                                 steady = 0;
    logic [stgd_pkg::SAMPLE_BITS-1:0]   cur_ax[3] = '{default: '0};
    logic [stgd_pkg::TIME_W-1:0]        cur_t = '0;
    int                                 n_setups = 0;
    int                                 quiet = 0;
    gesture_tracker                     sb;

    shake_tap_gesture_detector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random and check every gesture taken
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (o_out_valid && out_ready)
                sb.match_gesture(o_out_data);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("tb_shake_tap_gesture_detector failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one sample after random idle cycles and hold it until taken
    task automatic send_sample(input stgd_pkg::t_sample s);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!o_in_ready)
            @(posedge clk);
        sb.take_sample(s);
        cur_ax[0] = s.accel_x;
        cur_ax[1] = s.accel_y;
        cur_ax[2] = s.accel_z;
        cur_t     = s.sample_time_us;
    endtask

    // Wait until every queued gesture has drained and the pipeline is empty
    task automatic settle();
        while (sb.pending_gestures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; bits above its width carry random junk
    task automatic write_reg(input logic [stgd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value, input int width);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (width >= 32) ? '1 : (32'd1 << width) - 32'd1;
        data = ($urandom & ~mask) | (value & mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Bring the block to idle, then load a full register setup
    task automatic configure(input logic [31:0] thr, input logic [31:0] win,
                             input logic [31:0] hits, input logic [31:0] cool);
        in_valid <= 1'b0;
        settle();
        write_reg(stgd_pkg::CFG_DELTA_THRESHOLD, thr, stgd_pkg::THR_W);
        write_reg(stgd_pkg::CFG_WINDOW_LENGTH_US, win, stgd_pkg::WIN_W);
        write_reg(stgd_pkg::CFG_SHAKE_MIN_HITS, hits, stgd_pkg::HITS_W);
        write_reg(stgd_pkg::CFG_COOLDOWN_LENGTH_US, cool, stgd_pkg::COOL_W);
        write_reg(stgd_pkg::CFG_IDX_W'($urandom_range(
                      int'(stgd_pkg::CFG_COOLDOWN_LENGTH_US) + 1, 255)),
                  $urandom, 32);
        cfg_valid <= 1'b0;
        n_setups++;
    endtask

    // One setup followed by a random sample stream of the given shape
    task automatic run_phase(input logic [31:0] thr, input logic [31:0] win,
                             input logic [31:0] hits, input logic [31:0] cool,
                             input int count, input int jump_pct, input int ext_pct,
                             input int unsigned step_lo, input int unsigned step_hi,
                             input int back_pct, input int leap_bits, input bit calm);
        stgd_pkg::t_sample                s;
        logic [stgd_pkg::SAMPLE_BITS-1:0] ax[3];
        logic [stgd_pkg::TIME_W:0]        nt;
        int                               roll;
        configure(thr, win, hits, cool);
        if (leap_bits > 0)
            cur_t = cur_t + stgd_pkg::TIME_W'({$urandom, $urandom}
                                              & ((64'd1 << leap_bits) - 1));
        steady <= calm;
        repeat (count) begin
            // swing axes to the rails (some stay put), jump anywhere, or drift a little
            roll = $urandom_range(0, 99);
            for (int k = 0; k < 3; k++) begin
                if (roll < ext_pct)
                    ax[k] = ($urandom_range(0, 3) == 0) ? cur_ax[k] :
                            (cur_ax[k][stgd_pkg::SAMPLE_BITS-1] ? 16'h7FFF : 16'h8000);
                else if (roll < ext_pct + jump_pct)
                    ax[k] = stgd_pkg::SAMPLE_BITS'($urandom);
                else
                    ax[k] = cur_ax[k]
                          + stgd_pkg::SAMPLE_BITS'($urandom_range(0, 400)) - 16'd200;
            end
            // advance time, now and then step it back a little
            if ($urandom_range(0, 99) < back_pct)
                nt = (cur_t > 20) ? {1'b0, cur_t} - $urandom_range(0, 20) : {1'b0, cur_t};
            else
                nt = {1'b0, cur_t} + $urandom_range(step_lo, step_hi);
            if (nt > {1'b0, TIME_MAX})
                nt = {1'b0, TIME_MAX};
            s.accel_x        = ax[0];
            s.accel_y        = ax[1];
            s.accel_z        = ax[2];
            s.sample_time_us = nt[stgd_pkg::TIME_W-1:0];
            send_sample(s);
        end
        steady <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // first sample is only stored; a backward sample cannot close the window
        send_sample(stgd_pkg::t_sample'{16'sh7FFF, 16'sh8000, 16'sh0000, 48'd0});
        send_sample(stgd_pkg::t_sample'{16'sh8000, 16'sh7FFF, 16'sh8000, 48'd10});
        send_sample(stgd_pkg::t_sample'{16'sh8000, 16'sh7FFF, 16'sh8000, 48'd5});
        send_sample(stgd_pkg::t_sample'{16'sh0000, 16'sh0000, 16'sh0000, 48'd20});
        send_sample(stgd_pkg::t_sample'{16'sh0000, 16'sh0000, 16'sh0000, 48'd420010});
        // samples inside the cooldown still replace the stored sample
        send_sample(stgd_pkg::t_sample'{16'sh8000, 16'sh8000, 16'sh8000, 48'd500000});
        send_sample(stgd_pkg::t_sample'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 48'd1120009});

        // zero window, zero hit floor, largest reachable threshold
        configure(196605, 0, 0, 0);
        send_sample(stgd_pkg::t_sample'{16'sh8000, 16'sh8000, 16'sh8000, 48'd1120010});
        send_sample(stgd_pkg::t_sample'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 48'd1120010});
        send_sample(stgd_pkg::t_sample'{16'sh7FFE, 16'sh7FFF, 16'sh7FFF, 48'd1120011});

        // smallest threshold, highest hit floor, short cooldown
        configure(1, 3, 255, 2);
        send_sample(stgd_pkg::t_sample'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 48'd1120020});
        send_sample(stgd_pkg::t_sample'{16'sh0001, 16'shFFFF, 16'sh0000, 48'd1120021});
        send_sample(stgd_pkg::t_sample'{16'sh0001, 16'shFFFF, 16'sh0000, 48'd1120023});
        send_sample(stgd_pkg::t_sample'{16'sh0001, 16'shFFFF, 16'sh0000, 48'd1120024});

        // random stretches, one setup each
        run_phase(6500, 420000, 5, 700000, 100, 30, 10, 20000, 200000, 0, 0, 0);
        run_phase(1000, 50, 3, 40, 150, 35, 5, 1, 10, 3, 0, 0);
        run_phase(0, 400, 255, 0, 300, 20, 0, 1, 2, 0, 0, 1);
        run_phase(196605, 0, 1, 5, 150, 10, 50, 0, 4, 0, 0, 0);
        run_phase(20000, 100, 4, 200, 250, 40, 10, 1, 30, 2, 40, 0);
        run_phase(32'hFFFF_FFFF, 0, 1, 0, 50, 50, 30, 0, 10, 5, 0, 0);
        run_phase(500, 30, 0, 0, 200, 35, 5, 0, 8, 8, 0, 0);
        run_phase(3000, 16777215, 10, 16777215, 150, 40, 10, 1, 1 << 21, 2, 44, 0);
        // run the clock up to the top of the timestamp range
        cur_t = TIME_TOP;
        run_phase(100, 10, 2, 500, 80, 35, 5, 30, 90, 0, 0, 0);
        run_phase(4000, 0, 1, 16777215, 20, 50, 10, 0, 3, 0, 0, 0);

        in_valid <= 1'b0;
        settle();
        if (sb.pending_gestures.size() != 0) begin
            $error("%0d gestures never reported", sb.pending_gestures.size());
            sb.n_errors++;
        end
        $display("Ran %0d samples through %0d register setups (%0d register writes).",
                 sb.n_samples, n_setups, sb.n_writes);
        $display("Checked %0d gestures: %0d shakes, %0d taps, %0d with saturated hits.",
                 sb.n_gestures, sb.n_shakes, sb.n_gestures - sb.n_shakes, sb.n_saturated);
        if (sb.n_errors == 0)
            $display("tb_shake_tap_gesture_detector passed");
        else
            $display("tb_shake_tap_gesture_detector failed");
        $finish;
    end

endmodule
